>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define LBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LBS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants, types and fixed-point helpers of the skinning pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

	localparam int JointSlotsDefault = 64;
	localparam int FracBitsDefault   = 16;
	localparam int Influences        = 4;
	localparam int MatDim            = 4;
	localparam int MatWords          = MatDim * MatDim;
	localparam int OutRows           = 3;
	localparam int WordW             = 32;
	localparam int SlotW             = 6;
	localparam int SlotsW            = Influences * SlotW;
	localparam int ElemW             = 4;
	localparam int FuncW             = 2;
	localparam int WeightW           = 16;
	localparam int WeightBits        = 15;
	localparam int NumStages         = 8;
	localparam int ProdW             = 2 * WordW;
	localparam int WprodW            = WordW + WeightW + 1;
	localparam int SatW              = ProdW + 4;
	localparam int CfgIdxW           = 2;

	localparam logic [WeightW-1:0] WeightOne = WeightW'(32768);

	localparam logic [FuncW-1:0] FUNC_SKIN       = 2'd0;
	localparam logic [FuncW-1:0] FUNC_LOAD_JOINT = 2'd1;
	localparam logic [FuncW-1:0] FUNC_LOAD_BIND  = 2'd2;
	localparam logic [FuncW-1:0] FUNC_INVAL      = 2'd3;

	localparam logic [CfgIdxW-1:0] CFG_SKIN_ENABLE     = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_WEIGHTS_PRESENT = 2'd1;

	typedef logic signed [WordW-1:0] word_t;

	typedef struct packed {
		logic             we;
		logic [ElemW-1:0] elem;
		logic [WordW-1:0] value;
	} bind_wr_t;

	typedef struct packed {
		logic             we;
		logic [SlotW-1:0] slot;
		logic [ElemW-1:0] elem;
		logic [WordW-1:0] value;
	} joint_wr_t;

	function automatic word_t sat32(input logic signed [SatW-1:0] x);
		logic signed [SatW-1:0] hi;
		logic signed [SatW-1:0] lo;
		hi = {{(SatW-WordW+1){1'b0}}, {(WordW-1){1'b1}}};
		lo = {{(SatW-WordW+1){1'b1}}, {(WordW-1){1'b0}}};
		if (x > hi) begin
			return {1'b0, {(WordW-1){1'b1}}};
		end else if (x < lo) begin
			return {1'b1, {(WordW-1){1'b0}}};
		end
		return word_t'(x[WordW-1:0]);
	endfunction

	// round to nearest, ties up, then saturate
	function automatic word_t round_sat(input logic signed [SatW-1:0] x,
			input int unsigned sh);
		logic signed [SatW-1:0] half;
		half = SatW'(1) << (sh - 1);
		return sat32((x + half) >>> sh);
	endfunction

endpackage

`default_nettype wire

>>> sv/lbs_in_if.sv
// ----------------------------------------------------------------------------
// lbs_in_if
// Input channel: one vertex or table-load transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbs_in_if;
	logic                             valid;
	logic                             ready;
	logic [lbs_pkg::FuncW-1:0]        func;
	logic signed [lbs_pkg::WordW-1:0] pos_x;
	logic signed [lbs_pkg::WordW-1:0] pos_y;
	logic signed [lbs_pkg::WordW-1:0] pos_z;
	logic [lbs_pkg::SlotsW-1:0]       joint_slots;
	logic [lbs_pkg::WeightW-1:0]      weight_0;
	logic [lbs_pkg::WeightW-1:0]      weight_1;
	logic [lbs_pkg::WeightW-1:0]      weight_2;
	logic [lbs_pkg::WeightW-1:0]      weight_3;
	logic [lbs_pkg::SlotW-1:0]        matrix_slot;
	logic [lbs_pkg::ElemW-1:0]        matrix_element;
	logic signed [lbs_pkg::WordW-1:0] matrix_value;

	modport source(output valid, func, pos_x, pos_y, pos_z, joint_slots, weight_0,
		weight_1, weight_2, weight_3, matrix_slot, matrix_element, matrix_value,
		input ready);
	modport sink(input valid, func, pos_x, pos_y, pos_z, joint_slots, weight_0,
		weight_1, weight_2, weight_3, matrix_slot, matrix_element, matrix_value,
		output ready);
endinterface

`default_nettype wire

>>> sv/lbs_out_if.sv
// ----------------------------------------------------------------------------
// lbs_out_if
// Output channel: one skinned position transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbs_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [lbs_pkg::WordW-1:0] out_x;
	logic signed [lbs_pkg::WordW-1:0] out_y;
	logic signed [lbs_pkg::WordW-1:0] out_z;

	modport source(output valid, out_x, out_y, out_z, input ready);
	modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

>>> sv/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Path: an accepted skin transaction moves through the stage registers in order and leaves from the last stage.
// Throughput: one transaction per cycle while the output takes them; eight stages
// each hold one, and a stalled output backs up stage by stage, so bubbles still take input.
// Reset: pipeline empty, slot valid bits clear, bind matrix identity,
// skin_enable 0, weights_present 1; the joint table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module linear_blend_vertex_skinning #(
	parameter int JOINT_SLOTS   = lbs_pkg::JointSlotsDefault,
	parameter int FRACTION_BITS = lbs_pkg::FracBitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lbs_in_if.sink                      vertex,
	lbs_out_if.source                   result,
	input  logic                        cfg_we,
	input  logic [lbs_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [0:0]                  cfg_data
);

	localparam int Inf   = lbs_pkg::Influences;
	localparam int NS    = lbs_pkg::NumStages;
	localparam int AddrW = $clog2(JOINT_SLOTS);
	localparam int SW    = lbs_pkg::SlotW;

	logic                      skin_enable_q;
	logic                      weights_present_q;
	logic [NS:1]               stg_vld_q;
	logic [NS:1]               en;
	logic [JOINT_SLOTS-1:0]    slot_vld_q;

	logic [lbs_pkg::FuncW-1:0]   func_s1, func_s2;
	logic [SW-1:0]               slot_s1, slot_s2;
	logic [lbs_pkg::ElemW-1:0]   elem_s1, elem_s2;
	logic [lbs_pkg::WordW-1:0]   value_s1, value_s2;
	logic [lbs_pkg::SlotsW-1:0]  js_s1, js_s2;
	logic [lbs_pkg::WeightW-1:0] w_s1 [Inf];
	logic [lbs_pkg::WeightW-1:0] w_s2 [Inf];
	logic [lbs_pkg::WeightW-1:0] w_s3 [Inf];
	logic [Inf-1:0]              skip_s3;

	logic                      accept;
	logic                      slot_ok;
	logic                      slot_inval;
	logic [AddrW-1:0]          jwr_addr;
	lbs_pkg::bind_wr_t         bwr;
	lbs_pkg::joint_wr_t        jwr;
	lbs_pkg::word_t            b_s3 [lbs_pkg::MatDim];
	lbs_pkg::word_t            jm_s3 [Inf][lbs_pkg::MatWords];

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_enable_q     <= 1'b0;
			weights_present_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				lbs_pkg::CFG_SKIN_ENABLE:     skin_enable_q     <= cfg_data[0];
				lbs_pkg::CFG_WEIGHTS_PRESENT: weights_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its item moves on
	always_comb begin
		en[NS] = !stg_vld_q[NS] || result.ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !stg_vld_q[k] || en[k+1];
		end
	end

	assign vertex.ready = en[1];
	assign accept       = vertex.valid && en[1];
	assign result.valid = stg_vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (en[1]) stg_vld_q[1] <= vertex.valid;
			if (en[2]) stg_vld_q[2] <= stg_vld_q[1];
			if (en[3]) stg_vld_q[3] <= stg_vld_q[2] && func_s2 == lbs_pkg::FUNC_SKIN;
			for (int k = 4; k <= NS; k++) begin
				if (en[k]) stg_vld_q[k] <= stg_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			func_s1  <= vertex.func;
			slot_s1  <= vertex.matrix_slot;
			elem_s1  <= vertex.matrix_element;
			value_s1 <= vertex.matrix_value;
			js_s1    <= vertex.joint_slots;
			w_s1[0]  <= vertex.weight_0;
			w_s1[1]  <= vertex.weight_1;
			w_s1[2]  <= vertex.weight_2;
			w_s1[3]  <= vertex.weight_3;
		end
		if (en[2]) begin
			func_s2  <= func_s1;
			slot_s2  <= slot_s1;
			elem_s2  <= elem_s1;
			value_s2 <= value_s1;
			js_s2    <= js_s1;
			w_s2     <= w_s1;
		end
	end

	// bind words are written as the transaction is accepted
	assign bwr.we    = accept && vertex.func == lbs_pkg::FUNC_LOAD_BIND;
	assign bwr.elem  = vertex.matrix_element;
	assign bwr.value = vertex.matrix_value;

	// joint table and slot valid bits are touched on the move into stage 3
	assign slot_ok    = 32'(slot_s2) < JOINT_SLOTS;
	assign jwr_addr   = AddrW'(slot_s2);
	assign jwr.we     = en[3] && stg_vld_q[2] && func_s2 == lbs_pkg::FUNC_LOAD_JOINT && slot_ok;
	assign jwr.slot   = slot_s2;
	assign jwr.elem   = elem_s2;
	assign jwr.value  = value_s2;
	assign slot_inval = en[3] && stg_vld_q[2] && func_s2 == lbs_pkg::FUNC_INVAL && slot_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (jwr.we) begin
			slot_vld_q[jwr_addr] <= 1'b1;
		end else if (slot_inval) begin
			slot_vld_q[jwr_addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int k = 0; k < Inf; k++) begin
				w_s3[k]    <= weights_present_q ? w_s2[k] : lbs_pkg::WeightOne;
				skip_s3[k] <= (weights_present_q && w_s2[k] == '0)
					|| !(32'(js_s2[k*SW +: SW]) < JOINT_SLOTS)
					|| !slot_vld_q[AddrW'(js_s2[k*SW +: SW])];
			end
		end
	end

	lbs_bind #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_bind (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en[3:1]),
		.bwr   (bwr),
		.pos_x (vertex.pos_x),
		.pos_y (vertex.pos_y),
		.pos_z (vertex.pos_z),
		.b_s3  (b_s3)
	);

	for (genvar k = 0; k < Inf; k++) begin : g_jmem
		lbs_joint_mem #(
			.JOINT_SLOTS(JOINT_SLOTS)
		) u_jmem (
			.clk    (clk),
			.rd_en  (en[3]),
			.rd_slot(js_s2[k*SW +: SW]),
			.jwr    (jwr),
			.rd_data(jm_s3[k])
		);
	end

	lbs_blend #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_blend (
		.clk        (clk),
		.en         (en[NS:4]),
		.skin_enable(skin_enable_q),
		.b_s3       (b_s3),
		.m_s3       (jm_s3),
		.w_s3       (w_s3),
		.skip_s3    (skip_s3),
		.out_x      (result.out_x),
		.out_y      (result.out_y),
		.out_z      (result.out_z)
	);

	`LBS_ASSERT(a_full_stall_blocks, (&stg_vld_q) && !result.ready |-> !vertex.ready, "transaction taken into a full stalled pipeline")
	`LBS_ASSERT(a_jload_sets_valid, jwr.we |=> slot_vld_q[$past(jwr_addr)], "joint load did not mark slot valid")
	`LBS_ASSERT(a_inval_clears_valid, slot_inval |=> !slot_vld_q[$past(jwr_addr)], "invalidate left slot valid")
	`LBS_ASSERT(a_loads_leave_at_s3, en[3] && stg_vld_q[2] && func_s2 != lbs_pkg::FUNC_SKIN |=> !stg_vld_q[3], "load transaction passed into blend stages")

endmodule

`default_nettype wire

>>> sv/lbs_bind.sv
// ----------------------------------------------------------------------------
// lbs_bind
// Bind shape matrix registers and the bind transform, stages 1 to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_bind #(
	parameter int FRACTION_BITS = lbs_pkg::FracBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [3:1]        en,
	input  lbs_pkg::bind_wr_t bwr,
	input  lbs_pkg::word_t    pos_x,
	input  lbs_pkg::word_t    pos_y,
	input  lbs_pkg::word_t    pos_z,
	output lbs_pkg::word_t    b_s3 [lbs_pkg::MatDim]
);

	localparam int Dim = lbs_pkg::MatDim;
	localparam lbs_pkg::word_t One = lbs_pkg::word_t'(lbs_pkg::WordW'(1) << FRACTION_BITS);

	lbs_pkg::word_t bind_q [lbs_pkg::MatWords];
	lbs_pkg::word_t pos_s1 [Dim];
	logic signed [lbs_pkg::ProdW-1:0] bp_s2 [Dim][Dim];
	logic signed [lbs_pkg::SatW-1:0]  sum [Dim];

	for (genvar g = 0; g < lbs_pkg::MatWords; g++) begin : g_bind
		localparam lbs_pkg::word_t RstVal = (g / Dim == g % Dim) ? One : '0;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bind_q[g] <= RstVal;
			end else if (bwr.we && bwr.elem == lbs_pkg::ElemW'(g)) begin
				bind_q[g] <= bwr.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			pos_s1[3] <= One;
		end
		if (en[2]) begin
			for (int r = 0; r < Dim; r++) begin
				for (int c = 0; c < Dim; c++) begin
					bp_s2[r][c] <= bind_q[r*Dim+c] * pos_s1[c];
				end
			end
		end
		if (en[3]) begin
			for (int r = 0; r < Dim; r++) begin
				b_s3[r] <= lbs_pkg::round_sat(sum[r], FRACTION_BITS);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < Dim; r++) begin
			sum[r] = lbs_pkg::SatW'(bp_s2[r][0]) + lbs_pkg::SatW'(bp_s2[r][1])
				+ lbs_pkg::SatW'(bp_s2[r][2]) + lbs_pkg::SatW'(bp_s2[r][3]);
		end
	end

endmodule

`default_nettype wire

>>> sv/lbs_joint_mem.sv
// ----------------------------------------------------------------------------
// lbs_joint_mem
// One copy of the joint matrix table, one bank per matrix word, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_joint_mem #(
	parameter int JOINT_SLOTS = lbs_pkg::JointSlotsDefault
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [lbs_pkg::SlotW-1:0] rd_slot,
	input  lbs_pkg::joint_wr_t        jwr,
	output lbs_pkg::word_t            rd_data [lbs_pkg::MatWords]
);

	localparam int AddrW = $clog2(JOINT_SLOTS);

	logic [AddrW-1:0] waddr;
	logic [AddrW-1:0] raddr;

	assign waddr = AddrW'(jwr.slot);
	assign raddr = AddrW'(rd_slot);

	for (genvar e = 0; e < lbs_pkg::MatWords; e++) begin : g_bank
		lbs_pkg::word_t bank [JOINT_SLOTS];
		always_ff @(posedge clk) begin
			if (jwr.we && jwr.elem == lbs_pkg::ElemW'(e)) begin
				bank[waddr] <= jwr.value;
			end
			if (rd_en) begin
				rd_data[e] <= bank[raddr];
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/lbs_blend.sv
// ----------------------------------------------------------------------------
// lbs_blend
// Joint transforms, weighting and influence sum, stages 4 to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_blend #(
	parameter int FRACTION_BITS = lbs_pkg::FracBitsDefault
) (
	input  logic                        clk,
	input  logic [lbs_pkg::NumStages:4] en,
	input  logic                        skin_enable,
	input  lbs_pkg::word_t              b_s3 [lbs_pkg::MatDim],
	input  lbs_pkg::word_t              m_s3 [lbs_pkg::Influences][lbs_pkg::MatWords],
	input  logic [lbs_pkg::WeightW-1:0] w_s3 [lbs_pkg::Influences],
	input  logic [lbs_pkg::Influences-1:0] skip_s3,
	output lbs_pkg::word_t              out_x,
	output lbs_pkg::word_t              out_y,
	output lbs_pkg::word_t              out_z
);

	localparam int Inf  = lbs_pkg::Influences;
	localparam int Rows = lbs_pkg::OutRows;
	localparam int Dim  = lbs_pkg::MatDim;

	logic signed [lbs_pkg::ProdW-1:0]  jp_s4 [Inf][Rows][Dim];
	lbs_pkg::word_t                    bo_s4 [Rows];
	logic [lbs_pkg::WeightW-1:0]       w_s4 [Inf];
	logic [Inf-1:0]                    skip_s4;

	lbs_pkg::word_t                    t_s5 [Inf][Rows];
	lbs_pkg::word_t                    bo_s5 [Rows];
	logic [lbs_pkg::WeightW-1:0]       w_s5 [Inf];
	logic [Inf-1:0]                    skip_s5;

	logic signed [lbs_pkg::WprodW-1:0] wp_s6 [Inf][Rows];
	lbs_pkg::word_t                    bo_s6 [Rows];
	logic [Inf-1:0]                    skip_s6;

	lbs_pkg::word_t                    term_s7 [Inf][Rows];
	lbs_pkg::word_t                    bo_s7 [Rows];

	lbs_pkg::word_t                    res_s8 [Rows];

	logic signed [lbs_pkg::SatW-1:0]   jsum [Inf][Rows];
	logic signed [lbs_pkg::SatW-1:0]   acc [Rows];

	always_comb begin
		for (int k = 0; k < Inf; k++) begin
			for (int r = 0; r < Rows; r++) begin
				jsum[k][r] = lbs_pkg::SatW'(jp_s4[k][r][0]) + lbs_pkg::SatW'(jp_s4[k][r][1])
					+ lbs_pkg::SatW'(jp_s4[k][r][2]) + lbs_pkg::SatW'(jp_s4[k][r][3]);
			end
		end
		for (int r = 0; r < Rows; r++) begin
			acc[r] = lbs_pkg::SatW'(term_s7[0][r]) + lbs_pkg::SatW'(term_s7[1][r])
				+ lbs_pkg::SatW'(term_s7[2][r]) + lbs_pkg::SatW'(term_s7[3][r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int k = 0; k < Inf; k++) begin
				for (int r = 0; r < Rows; r++) begin
					for (int c = 0; c < Dim; c++) begin
						jp_s4[k][r][c] <= m_s3[k][r*Dim+c] * b_s3[c];
					end
				end
				w_s4[k] <= w_s3[k];
			end
			for (int r = 0; r < Rows; r++) begin
				bo_s4[r] <= b_s3[r];
			end
			skip_s4 <= skip_s3;
		end
		if (en[5]) begin
			for (int k = 0; k < Inf; k++) begin
				for (int r = 0; r < Rows; r++) begin
					t_s5[k][r] <= lbs_pkg::round_sat(jsum[k][r], FRACTION_BITS);
				end
				w_s5[k] <= w_s4[k];
			end
			bo_s5   <= bo_s4;
			skip_s5 <= skip_s4;
		end
		if (en[6]) begin
			for (int k = 0; k < Inf; k++) begin
				for (int r = 0; r < Rows; r++) begin
					wp_s6[k][r] <= t_s5[k][r] * signed'({1'b0, w_s5[k]});
				end
			end
			bo_s6   <= bo_s5;
			skip_s6 <= skip_s5;
		end
		if (en[7]) begin
			for (int k = 0; k < Inf; k++) begin
				for (int r = 0; r < Rows; r++) begin
					term_s7[k][r] <= skip_s6[k] ? '0
						: lbs_pkg::round_sat(lbs_pkg::SatW'(wp_s6[k][r]), lbs_pkg::WeightBits);
				end
			end
			bo_s7 <= bo_s6;
		end
		if (en[8]) begin
			for (int r = 0; r < Rows; r++) begin
				res_s8[r] <= skin_enable ? lbs_pkg::sat32(acc[r]) : bo_s7[r];
			end
		end
	end

	assign out_x = res_s8[0];
	assign out_y = res_s8[1];
	assign out_z = res_s8[2];

endmodule

`default_nettype wire

>>> verif/tb_linear_blend_vertex_skinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_blend_vertex_skinning
// Drives vertex and table-load transactions through the skinning pipeline.
// A built-in predictor tracks bind matrix, joint table and slot valid bits
// and checks every output transaction in order, under random idling and a
// long output stall, across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_blend_vertex_skinning;

	localparam int Slots     = lbs_pkg::JointSlotsDefault;
	localparam int Frac      = lbs_pkg::FracBitsDefault;
	localparam int CycleCap  = 400000;
	localparam int RandItems = 240;

	typedef struct packed {
		logic [lbs_pkg::FuncW-1:0]   func;
		logic [lbs_pkg::WordW-1:0]   px;
		logic [lbs_pkg::WordW-1:0]   py;
		logic [lbs_pkg::WordW-1:0]   pz;
		logic [lbs_pkg::SlotsW-1:0]  slots;
		logic [lbs_pkg::WeightW-1:0] w0;
		logic [lbs_pkg::WeightW-1:0] w1;
		logic [lbs_pkg::WeightW-1:0] w2;
		logic [lbs_pkg::WeightW-1:0] w3;
		logic [lbs_pkg::SlotW-1:0]   mslot;
		logic [lbs_pkg::ElemW-1:0]   melem;
		logic [lbs_pkg::WordW-1:0]   mval;
	} vtx_t;

	typedef struct packed {
		logic [lbs_pkg::WordW-1:0] x;
		logic [lbs_pkg::WordW-1:0] y;
		logic [lbs_pkg::WordW-1:0] z;
	} pos_t;

	typedef struct {
		vtx_t v;
		bit   known;
		pos_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lbs_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [0:0] cfg_data = '0;

	lbs_in_if vertex();
	lbs_out_if result();

	linear_blend_vertex_skinning uut (
		.clk(clk), .arst_n(arst_n), .vertex(vertex.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [lbs_pkg::WordW-1:0] joint_tbl [Slots*lbs_pkg::MatWords];
	bit slot_ok [Slots];
	bit slot_written [Slots];
	logic signed [lbs_pkg::WordW-1:0] bind_mat [lbs_pkg::MatWords];
	bit skin_on;
	bit weights_on;

	pos_t expected_pos [$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 17;
	int recv_idle = 74;
	bit hold_off = 1'b0;
	row_t directed [$];

	task automatic report(input string what, input logic [lbs_pkg::WordW-1:0] got,
			input logic [lbs_pkg::WordW-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic signed [lbs_pkg::WordW-1:0] clamp32(
			input logic signed [95:0] x);
		if (x > 96'sh7FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end
		if (x < -96'sh80000000) begin
			return 32'sh80000000;
		end
		return x[lbs_pkg::WordW-1:0];
	endfunction

	function automatic logic signed [lbs_pkg::WordW-1:0] mat_row(input int base,
			input int r,
			input logic signed [lbs_pkg::WordW-1:0] m [lbs_pkg::MatWords],
			input logic signed [lbs_pkg::WordW-1:0] vec [4]);
		logic signed [95:0] acc;
		acc = 0;
		for (int c = 0; c < 4; c++) begin
			acc += 96'(m[base + r*4 + c]) * 96'(vec[c]);
		end
		return clamp32((acc + (96'sd1 <<< (Frac-1))) >>> Frac);
	endfunction

	function automatic pos_t skin_vertex(input vtx_t v);
		logic signed [lbs_pkg::WordW-1:0] p [4];
		logic signed [lbs_pkg::WordW-1:0] b [4];
		logic signed [lbs_pkg::WordW-1:0] jm [lbs_pkg::MatWords];
		logic signed [lbs_pkg::WordW-1:0] t;
		logic signed [95:0] acc [3];
		logic signed [95:0] prod;
		logic [lbs_pkg::WeightW-1:0] w;
		logic [lbs_pkg::SlotW-1:0] js;
		logic signed [lbs_pkg::WordW-1:0] r [3];
		pos_t o;
		p[0] = v.px; p[1] = v.py; p[2] = v.pz; p[3] = 32'sd1 <<< Frac;
		if (!skin_on) begin
			for (int i = 0; i < 3; i++) r[i] = mat_row(0, i, bind_mat, p);
		end else begin
			for (int i = 0; i < 4; i++) b[i] = mat_row(0, i, bind_mat, p);
			for (int i = 0; i < 3; i++) acc[i] = 0;
			for (int k = 0; k < lbs_pkg::Influences; k++) begin
				case (k)
					0: w = v.w0;
					1: w = v.w1;
					2: w = v.w2;
					default: w = v.w3;
				endcase
				if (!weights_on) w = lbs_pkg::WeightOne;
				js = v.slots[k*lbs_pkg::SlotW +: lbs_pkg::SlotW];
				if (w != 0 && slot_ok[js]) begin
					for (int e = 0; e < lbs_pkg::MatWords; e++)
						jm[e] = joint_tbl[js*lbs_pkg::MatWords + e];
					for (int i = 0; i < 3; i++) begin
						t = mat_row(0, i, jm, b);
						prod = 96'(t) * $signed({80'd0, w})
							+ (96'sd1 <<< (lbs_pkg::WeightBits-1));
						acc[i] += 96'(clamp32(prod >>> lbs_pkg::WeightBits));
					end
				end
			end
			for (int i = 0; i < 3; i++) r[i] = clamp32(acc[i]);
		end
		o.x = r[0]; o.y = r[1]; o.z = r[2];
		return o;
	endfunction

	// updates state; returns 1 when a result is due
	function automatic bit apply_item(input vtx_t v, output pos_t o);
		o = '0;
		case (v.func)
			lbs_pkg::FUNC_LOAD_JOINT: begin
				joint_tbl[v.mslot*lbs_pkg::MatWords + v.melem] = v.mval;
				slot_ok[v.mslot] = 1'b1;
				return 1'b0;
			end
			lbs_pkg::FUNC_LOAD_BIND: begin
				bind_mat[v.melem] = v.mval;
				return 1'b0;
			end
			lbs_pkg::FUNC_INVAL: begin
				slot_ok[v.mslot] = 1'b0;
				return 1'b0;
			end
			default: begin
				o = skin_vertex(v);
				return 1'b1;
			end
		endcase
	endfunction

	task automatic write_reg(input logic [lbs_pkg::CfgIdxW-1:0] idx, input bit val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == lbs_pkg::CFG_SKIN_ENABLE) skin_on = val;
		else weights_on = val;
	endtask

	task automatic drain();
		vertex.valid <= 1'b0;
		while (expected_pos.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic send(input vtx_t v, input bit known, input pos_t want);
		pos_t o;
		while ($urandom_range(99) < send_idle) begin
			vertex.valid <= 1'b0;
			@(posedge clk);
		end
		vertex.valid <= 1'b1;
		{vertex.func, vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.joint_slots,
			vertex.weight_0, vertex.weight_1, vertex.weight_2, vertex.weight_3,
			vertex.matrix_slot, vertex.matrix_element, vertex.matrix_value} <= v;
		do @(posedge clk); while (!vertex.ready);
		if (apply_item(v, o)) begin
			if (known) o = want;
			expected_pos = {expected_pos, o};
		end
	endtask

	function automatic vtx_t rand_vtx();
		vtx_t v;
		v = vtx_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, 4'($urandom)});
		return v;
	endfunction

	function automatic logic [lbs_pkg::SlotW-1:0] written_slot();
		logic [lbs_pkg::SlotW-1:0] s;
		do s = lbs_pkg::SlotW'($urandom_range(Slots-1)); while (!slot_written[s]);
		return s;
	endfunction

	// random item: skins reference only slots whose words are all loaded
	function automatic vtx_t rand_item();
		vtx_t v;
		int pick;
		v = rand_vtx();
		pick = $urandom_range(99);
		if (pick < 55) begin
			v.func = lbs_pkg::FUNC_SKIN;
			for (int k = 0; k < lbs_pkg::Influences; k++) begin
				if ($urandom_range(9) < 8)
					v.slots[k*lbs_pkg::SlotW +: lbs_pkg::SlotW] = written_slot();
				else if (!slot_written[v.slots[k*lbs_pkg::SlotW +: lbs_pkg::SlotW]])
					v.slots[k*lbs_pkg::SlotW +: lbs_pkg::SlotW] = written_slot();
			end
			if ($urandom_range(3) != 0) begin
				v.px = $signed(16'($urandom)) <<< 8;
				v.py = $signed(16'($urandom)) <<< 8;
				v.pz = $signed(16'($urandom)) <<< 8;
				v.w0 = lbs_pkg::WeightW'($urandom_range(lbs_pkg::WeightOne));
				v.w1 = lbs_pkg::WeightW'($urandom_range(lbs_pkg::WeightOne));
				v.w2 = lbs_pkg::WeightW'($urandom_range(lbs_pkg::WeightOne));
				v.w3 = lbs_pkg::WeightW'($urandom_range(lbs_pkg::WeightOne));
			end
		end else if (pick < 75) begin
			v.func = lbs_pkg::FUNC_LOAD_JOINT;
			v.mslot = written_slot();
			if ($urandom_range(1)) v.mval = $signed(20'($urandom));
		end else if (pick < 85) begin
			v.func = lbs_pkg::FUNC_LOAD_BIND;
			v.mval = (v.melem % 5 == 0) ? (32'sd1 <<< Frac) + $signed(12'($urandom))
				: $signed(14'($urandom));
		end else begin
			v.func = lbs_pkg::FUNC_INVAL;
		end
		return v;
	endfunction

	task automatic load_slot(input int s, input bit ident);
		vtx_t v;
		for (int e = 0; e < lbs_pkg::MatWords; e++) begin
			v = rand_vtx();
			v.func = lbs_pkg::FUNC_LOAD_JOINT;
			v.mslot = lbs_pkg::SlotW'(s);
			v.melem = lbs_pkg::ElemW'(e);
			v.mval = ident ? ((e % 5 == 0) ? (32'sd1 <<< Frac) : 0)
				: ((e % 5 == 0) ? (32'sd1 <<< Frac) + $signed(14'($urandom))
				: $signed(18'($urandom)));
			send(v, 1'b0, '0);
		end
		slot_written[s] = 1'b1;
	endtask

	task automatic add_row(input logic [lbs_pkg::FuncW-1:0] f,
			input logic [lbs_pkg::WordW-1:0] x, input logic [lbs_pkg::WordW-1:0] y,
			input logic [lbs_pkg::WordW-1:0] z, input bit known, input pos_t want);
		row_t r;
		r.v = rand_vtx();
		r.v.func = f; r.v.px = x; r.v.py = y; r.v.pz = z;
		r.known = known;
		r.res = want;
		directed = {directed, r};
	endtask

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		pos_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_pos.size() == 0) begin
				report("unexpected transaction", result.out_x, '0);
			end else begin
				want = expected_pos.pop_front();
				if (result.out_x !== want.x) report("out_x", result.out_x, want.x);
				if (result.out_y !== want.y) report("out_y", result.out_y, want.y);
				if (result.out_z !== want.z) report("out_z", result.out_z, want.z);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleCap) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		vtx_t v;
		pos_t zero;
		zero = '0;
		vertex.valid = 1'b0;
		{vertex.func, vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.joint_slots,
			vertex.weight_0, vertex.weight_1, vertex.weight_2, vertex.weight_3,
			vertex.matrix_slot, vertex.matrix_element, vertex.matrix_value} = '0;
		for (int i = 0; i < Slots; i++) begin
			slot_ok[i] = 1'b0;
			slot_written[i] = 1'b0;
		end
		for (int i = 0; i < Slots*lbs_pkg::MatWords; i++) joint_tbl[i] = 0;
		for (int i = 0; i < lbs_pkg::MatWords; i++)
			bind_mat[i] = (i % 5 == 0) ? (32'sd1 <<< Frac) : 0;
		skin_on = 1'b0;
		weights_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: identity bind, bind-only mode
		add_row(lbs_pkg::FUNC_SKIN, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1,
			'{32'h0001_0000, 32'hFFFF_0000, 32'h0});
		add_row(lbs_pkg::FUNC_SKIN, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
		add_row(lbs_pkg::FUNC_SKIN, 32'h0, 32'h0, 32'h0, 1'b1, zero);
		foreach (directed[i]) send(directed[i].v, directed[i].known, directed[i].res);
		directed.delete();
		drain();

		// load a few slots and skin with slots that were never made valid
		write_reg(lbs_pkg::CFG_SKIN_ENABLE, 1'b1);
		v = rand_vtx(); v.func = lbs_pkg::FUNC_SKIN; v.slots = '0;
		send(v, 1'b1, zero);
		load_slot(0, 1'b1);
		load_slot(Slots-1, 1'b0);
		for (int s = 1; s < 6; s++) load_slot(s, s == 1);
		// weight extremes, zero weights, out of range bind values
		v = rand_vtx(); v.func = lbs_pkg::FUNC_SKIN;
		v.slots = {6'd0, 6'd1, 6'(Slots-1), 6'd0};
		v.w0 = lbs_pkg::WeightOne; v.w1 = 16'hFFFF; v.w2 = '0; v.w3 = 16'h0001;
		send(v, 1'b0, '0);
		v.px = 32'h7FFF_FFFF; v.py = 32'h8000_0000; send(v, 1'b0, '0);
		v = rand_item(); v.func = lbs_pkg::FUNC_LOAD_BIND; v.melem = 15;
		v.mval = 32'h8000_0000;
		send(v, 1'b0, '0);
		v = rand_vtx(); v.func = lbs_pkg::FUNC_SKIN; v.slots = {6'd3, 6'd2, 6'd1, 6'd0};
		send(v, 1'b0, '0);
		v = rand_item(); v.func = lbs_pkg::FUNC_LOAD_BIND; v.melem = 15;
		v.mval = 32'sd1 <<< Frac;
		send(v, 1'b0, '0);
		// invalidate then skin: words stay but slot is skipped
		v = rand_vtx(); v.func = lbs_pkg::FUNC_INVAL; v.mslot = 1; send(v, 1'b0, '0);
		v = rand_vtx(); v.func = lbs_pkg::FUNC_SKIN; v.slots = {4{6'd1}};
		send(v, 1'b1, zero);
		v = rand_vtx(); v.func = lbs_pkg::FUNC_LOAD_JOINT; v.mslot = 1; v.melem = 0;
		v.mval = 32'sd1 <<< Frac; send(v, 1'b0, '0);
		drain();
		write_reg(lbs_pkg::CFG_WEIGHTS_PRESENT, 1'b0);
		v = rand_vtx(); v.func = lbs_pkg::FUNC_SKIN; v.slots = {6'd2, 6'd3, 6'd4, 6'd5};
		send(v, 1'b0, '0);
		drain();
		write_reg(lbs_pkg::CFG_WEIGHTS_PRESENT, 1'b1);

		// long output stall while input keeps coming
		fork
			begin
				hold_off = 1'b1;
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_idle = 0;
				for (int i = 0; i < 30; i++) send(rand_item(), 1'b0, '0);
			end
		join
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 17 : (ph == 1) ? 74 : 0;
			recv_idle = (ph == 0) ? 74 : (ph == 1) ? 17 : 0;
			write_reg(lbs_pkg::CFG_SKIN_ENABLE, ph != 1);
			write_reg(lbs_pkg::CFG_WEIGHTS_PRESENT, ph != 2);
			for (int i = 0; i < RandItems/3; i++) send(rand_item(), 1'b0, '0);
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
